// ----- hdl/assert_macros.svh -----
// Assertion shorthands shared by the allocator RTL.
// Each use expects signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge out of reset.
`define CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Condition on one edge implies a condition on the next edge.
`define CHK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hdl/mnva_pkg.sv -----
// Shared types and constants for the MIDI note voice allocator.
// Used by mnva_ctrl, mnva_datapath and the top level; no dependencies.
`default_nettype none

package mnva_pkg;

  localparam int VOICES_DEFAULT = 8;
  localparam int IN_W           = 8;
  localparam int NOTE_W         = 7;
  localparam int KIND_W         = 2;
  localparam int SLOT_W         = 3;
  localparam int PACK_SLOTS     = 8;
  localparam int ACT_W          = PACK_SLOTS * NOTE_W;
  localparam int OUT_FIELDS_W   = 1 + KIND_W + SLOT_W + 2 * NOTE_W + ACT_W;
  localparam int OUT_W          = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [IN_W-1:0] STATUS_OFF = 8'd128;
  localparam logic [IN_W-1:0] STATUS_ON  = 8'd144;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE     = 2'd0,
    EV_STORED   = 2'd1,
    EV_RELEASED = 2'd2,
    EV_NOMATCH  = 2'd3
  } event_kind_t;

  // MIDI parser phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_NOTE = 3'b010,
    PH_VEL  = 3'b100
  } phase_t;

  // What the current byte asks of the slot file
  typedef enum logic [1:0] {
    DEC_NONE    = 2'd0,
    DEC_STORE   = 2'd1,
    DEC_RELEASE = 2'd2
  } dec_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_ADV    = 5'b00100,
    ST_MATCH  = 5'b01000,
    ST_EMIT   = 5'b10000
  } ctl_state_t;

  typedef struct packed {
    logic load_byte;
    logic apply_decode;
    logic adv_step;
    logic match_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    dec_t dec;
    logic free_hit;
    logic adv_last;
    logic match_hit;
    logic match_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- hdl/mnva_ctrl.sv -----
// Sequencer for the allocator: accept, decode, slot scan, result hand-off.
// Depends on mnva_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mnva_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire mnva_pkg::stat_t stat,
  output mnva_pkg::cmd_t       cmd
);
  import mnva_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_byte = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.apply_decode = 1'b1;
        unique case (stat.dec)
          DEC_STORE:   state_next = ST_ADV;
          DEC_RELEASE: state_next = ST_MATCH;
          default:     state_next = ST_EMIT;
        endcase
      end
      ST_ADV: begin
        cmd.adv_step = 1'b1;
        if (stat.free_hit || stat.adv_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_MATCH: begin
        cmd.match_step = 1'b1;
        if (stat.match_hit || stat.match_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `CHK_NEXT(a_accept_decodes, s_tvalid && s_tready, state == ST_DECODE, "beat not decoded")
  `CHK(a_one_beat_inflight, !(s_tready && (cmd.emit || cmd.adv_step)), "accept while busy")
  `CHK_NEXT(a_emit_to_idle, cmd.emit, state == ST_IDLE, "emit did not return to idle")

endmodule

`default_nettype wire

// ----- hdl/mnva_datapath.sv -----
// Datapath: MIDI parser registers, voice slot file, scan counter, result register.
// Depends on mnva_pkg and assert_macros.svh; driven by mnva_ctrl commands.
`default_nettype none
`include "assert_macros.svh"

module mnva_datapath #(
  parameter int VOICES = mnva_pkg::VOICES_DEFAULT
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire  [mnva_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire                        m_tready,
  output logic [mnva_pkg::OUT_W-1:0] m_tdata,
  input  wire  mnva_pkg::cmd_t       cmd,
  output mnva_pkg::stat_t            stat
);
  import mnva_pkg::*;

  localparam int IDXW   = $clog2(VOICES);
  localparam int PACK_N = (VOICES < PACK_SLOTS) ? VOICES : PACK_SLOTS;
  localparam int PAD_W  = OUT_W - OUT_FIELDS_W;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(VOICES - 1);

  // parser state
  logic [IN_W-1:0]   rx_byte;
  phase_t            phase, phase_next;
  logic              last_on, last_on_next;
  logic [NOTE_W-1:0] pending_note, pending_next;
  dec_t              dec;

  // slot file and scan
  logic [NOTE_W-1:0] voices [VOICES];
  logic [IDXW-1:0]   alloc_ptr;
  logic [IDXW-1:0]   cnt;
  logic [IDXW-1:0]   cnt_inc;
  logic [IDXW-1:0]   ptr_inc;
  logic [NOTE_W-1:0] scan_note;

  // result in progress
  logic              res_done;
  event_kind_t       res_kind;
  logic [SLOT_W-1:0] res_slot;
  logic [NOTE_W-1:0] res_note;
  logic [NOTE_W-1:0] res_vel;

  // result register
  logic              out_done;
  event_kind_t       out_kind;
  logic [SLOT_W-1:0] out_slot;
  logic [NOTE_W-1:0] out_note;
  logic [NOTE_W-1:0] out_vel;
  logic [ACT_W-1:0]  out_active;
  logic [ACT_W-1:0]  packed_slots;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDXW-1:0] idx);
    logic [IDXW+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

  // byte decode against the parser phase
  always_comb begin
    phase_next   = phase;
    last_on_next = last_on;
    pending_next = pending_note;
    dec          = DEC_NONE;
    unique case (phase)
      PH_IDLE: begin
        if (rx_byte[IN_W-1]) begin
          if (rx_byte == STATUS_OFF || rx_byte == STATUS_ON) begin
            last_on_next = (rx_byte == STATUS_ON);
            phase_next   = PH_NOTE;
          end
        end else begin
          // running status: data byte is the note under the last status
          pending_next = rx_byte[NOTE_W-1:0];
          phase_next   = PH_VEL;
        end
      end
      PH_NOTE: begin
        if (!rx_byte[IN_W-1]) begin
          pending_next = rx_byte[NOTE_W-1:0];
          phase_next   = PH_VEL;
        end
      end
      PH_VEL: begin
        if (!rx_byte[IN_W-1]) begin
          phase_next = PH_IDLE;
          dec = (last_on && rx_byte[NOTE_W-1:0] != '0) ? DEC_STORE : DEC_RELEASE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  assign cnt_inc   = (cnt == LAST_IDX) ? '0 : cnt + IDXW'(1);
  assign ptr_inc   = (alloc_ptr == LAST_IDX) ? '0 : alloc_ptr + IDXW'(1);
  assign scan_note = voices[cnt];

  assign stat.dec        = dec;
  assign stat.free_hit   = (scan_note == '0);
  assign stat.adv_last   = (cnt == alloc_ptr);
  assign stat.match_hit  = (scan_note == res_note);
  assign stat.match_last = (cnt == LAST_IDX);
  assign stat.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      last_on      <= 1'b0;
      pending_note <= '0;
      alloc_ptr    <= '0;
      for (int k = 0; k < VOICES; k++) begin
        voices[k] <= '0;
      end
    end else begin
      if (cmd.apply_decode) begin
        phase        <= phase_next;
        last_on      <= last_on_next;
        pending_note <= pending_next;
        if (dec == DEC_STORE) begin
          voices[alloc_ptr] <= pending_note;
        end
      end
      if (cmd.adv_step && stat.free_hit) begin
        alloc_ptr <= cnt;
      end
      if (cmd.match_step && stat.match_hit) begin
        voices[cnt] <= '0;
      end
    end
  end

  // scan counter and result fields
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      rx_byte <= s_tdata;
    end
    if (cmd.apply_decode) begin
      res_done <= (dec != DEC_NONE);
      res_note <= (dec != DEC_NONE) ? pending_note : '0;
      res_vel  <= (dec != DEC_NONE) ? rx_byte[NOTE_W-1:0] : '0;
      res_slot <= (dec == DEC_STORE) ? to_slot(alloc_ptr) : '0;
      cnt      <= (dec == DEC_STORE) ? ptr_inc : '0;
      case (dec)
        DEC_STORE:   res_kind <= EV_STORED;
        DEC_RELEASE: res_kind <= EV_NOMATCH;
        default:     res_kind <= EV_NONE;
      endcase
    end
    if (cmd.adv_step && !stat.free_hit) begin
      cnt <= cnt_inc;
    end
    if (cmd.match_step) begin
      if (stat.match_hit) begin
        res_kind <= EV_RELEASED;
        res_slot <= to_slot(cnt);
      end else begin
        cnt <= cnt_inc;
      end
    end
  end

  always_comb begin
    packed_slots = '0;
    for (int k = 0; k < PACK_N; k++) begin
      packed_slots[k*NOTE_W +: NOTE_W] = voices[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_done   <= res_done;
      out_kind   <= res_kind;
      out_slot   <= res_slot;
      out_note   <= res_note;
      out_vel    <= res_vel;
      out_active <= packed_slots;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_active, out_vel, out_note, out_slot, out_kind, out_done};

  `CHK(a_ptr_range, alloc_ptr <= LAST_IDX, "allocation pointer out of range")
  `CHK(a_done_kind, !m_tvalid || (out_done == (out_kind != EV_NONE)), "done and kind disagree")
  `CHK(a_nomatch_slot, !m_tvalid || out_kind != EV_NOMATCH || out_slot == '0, "bad miss slot")

endmodule

`default_nettype wire

// ----- hdl/midi_note_voice_allocator.sv -----
// MIDI note voice allocator. Takes one received MIDI byte per input beat and
// returns exactly one result beat per byte. Channel-1 note-on (144) and
// note-off (128) are parsed with running status; a note-on with nonzero
// velocity stores the note in the slot under the allocation pointer, which
// then moves to the next free slot (wrapping) or stays if none is free; a
// note-off or zero-velocity note-on clears the lowest slot with that note.
// A byte that completes no message is accepted, decoded and handed off; a
// note message also scans the slot register file between decode and
// hand-off, one slot per cycle.
// A new byte is taken while the previous result still waits on m_tready.
// Depends on mnva_pkg, mnva_ctrl and mnva_datapath.
`default_nettype none

module midi_note_voice_allocator #(
  parameter int VOICES = mnva_pkg::VOICES_DEFAULT
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        s_tvalid,
  output logic                       s_tready,
  input  wire  [mnva_pkg::IN_W-1:0]  s_tdata,  // rx_byte
  output logic                       m_tvalid,
  input  wire                        m_tready,
  // message_done, event_kind, slot_index, note_number, note_velocity,
  // active_notes, zero pad
  output logic [mnva_pkg::OUT_W-1:0] m_tdata
);
  import mnva_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mnva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mnva_datapath #(
    .VOICES (VOICES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire
